// File: sv/assert_macros.svh
// Assertion macros for the checker file of the calendar row core.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds after the delay given by the argument n, counted from the antecedent.
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
		else $error("assertion failed");

`endif

// File: sv/cmr_pkg.sv
// Constants and helper functions for the calendar month week row core.
// Depends on nothing; used by the core and its checker.
package cmr_pkg;

	localparam int unsigned LATENCY = 5;

	localparam logic [13:0] MAX_YEAR      = 14'd9999;
	localparam logic [13:0] CHANGE_YEAR   = 14'd1752;
	localparam logic [3:0]  CHANGE_MONTH  = 4'd9;
	localparam logic [6:0]  SKIPPED_DAYS  = 7'd11;
	localparam logic [9:0]  ZELLER_BIAS   = 10'd370;
	localparam logic [12:0] DIV100_RECIP  = 13'd5243;
	localparam int unsigned DIV100_SHIFT  = 19;

	// Length of a month; the month is known to lie in 1 to 12.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// The term 13 * (m + 1) / 5 of the congruence, with m running from 3 (March) to 14.
	function automatic logic [5:0] month_term(input logic [3:0] month);
		logic [5:0] t;
		case (month)
			4'd1:  t = 6'd36;
			4'd2:  t = 6'd39;
			4'd3:  t = 6'd10;
			4'd4:  t = 6'd13;
			4'd5:  t = 6'd15;
			4'd6:  t = 6'd18;
			4'd7:  t = 6'd20;
			4'd8:  t = 6'd23;
			4'd9:  t = 6'd26;
			4'd10: t = 6'd28;
			4'd11: t = 6'd31;
			default: t = 6'd33;
		endcase
		return t;
	endfunction

	// Remainder by seven, folding octal digits since eight is one more than seven.
	function automatic logic [2:0] mod7(input logic [9:0] v);
		logic [4:0] a;
		logic [3:0] b;
		a = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[9]);
		b = 4'(a[2:0]) + 4'(a[4:3]);
		return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
	endfunction

endpackage

// File: sv/calendar_month_week_row_core.sv
// Calendar month week row core: one row of a Sunday-first month grid.
// A new item may be started in every cycle; busy is always low.
// Five pipeline stages: division by a hundred, leap and era terms, congruence sum,
// remainder by seven, and the seven day columns.
// Reset clears the stage valid bits only; data registers are not reset.
module calendar_month_week_row_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [2:0]  week_row,
	output logic        done,
	output logic [4:0]  day_col0,
	output logic [4:0]  day_col1,
	output logic [4:0]  day_col2,
	output logic [4:0]  day_col3,
	output logic [4:0]  day_col4,
	output logic [4:0]  day_col5,
	output logic [4:0]  day_col6,
	output logic [4:0]  days_in_month,
	output logic [2:0]  first_weekday
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// Stage 1
	logic [13:0] zy_c;
	logic [26:0] yprod_c, zprod_c;
	logic        ok_s1;
	logic [13:0] year_s1, zy_s1;
	logic [3:0]  month_s1;
	logic [2:0]  row_s1;
	logic [6:0]  cy_s1, cz_s1;

	// Stage 2
	logic [13:0] k_full_c;
	logic        leap_c;
	logic        ok_s2, greg_s2, sept_s2;
	logic [2:0]  row_s2;
	logic [4:0]  ndays_s2;
	logic [5:0]  mt_s2;
	logic [6:0]  k_s2, c_s2;

	// Stage 3
	logic [9:0]  sum_c;
	logic        ok_s3, sept_s3;
	logic [2:0]  row_s3;
	logic [4:0]  ndays_s3;
	logic [9:0]  sum_s3;

	// Stage 4
	logic        ok_s4, sept_s4;
	logic [2:0]  row_s4;
	logic [4:0]  ndays_s4;
	logic [2:0]  dow_s4;

	// Stage 5
	logic [4:0]  day_c [7];
	logic [6:0]  idx_c [7];
	logic [6:0]  hi_c;
	logic [4:0]  day_s5 [7];
	logic [4:0]  ndays_s5;
	logic [2:0]  dow_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: range check and quotients by a hundred through a reciprocal product.
	always_comb begin
		zy_c    = year - ((month <= 4'd2) ? 14'd1 : 14'd0);
		yprod_c = 27'(year) * 27'(cmr_pkg::DIV100_RECIP);
		zprod_c = 27'(zy_c) * 27'(cmr_pkg::DIV100_RECIP);
	end

	always_ff @(posedge clk) begin
		ok_s1    <= (year != 14'd0) && (year <= cmr_pkg::MAX_YEAR) &&
			(month != 4'd0) && (month <= 4'd12);
		year_s1  <= year;
		zy_s1    <= zy_c;
		month_s1 <= month;
		row_s1   <= week_row;
		cy_s1    <= yprod_c[cmr_pkg::DIV100_SHIFT +: 7];
		cz_s1    <= zprod_c[cmr_pkg::DIV100_SHIFT +: 7];
	end

	// Stage 2: year within century, leap rule by era, month length.
	always_comb begin
		k_full_c = zy_s1 - 14'(cz_s1) * 14'd100;
		if (year_s1 <= cmr_pkg::CHANGE_YEAR) begin
			leap_c = (year_s1[1:0] == 2'd0);
		end else begin
			leap_c = (year_s1[1:0] == 2'd0) &&
				((year_s1 != 14'(cy_s1) * 14'd100) || (cy_s1[1:0] == 2'd0));
		end
	end

	always_ff @(posedge clk) begin
		ok_s2    <= ok_s1;
		row_s2   <= row_s1;
		greg_s2  <= (year_s1 > cmr_pkg::CHANGE_YEAR) ||
			((year_s1 == cmr_pkg::CHANGE_YEAR) && (month_s1 > cmr_pkg::CHANGE_MONTH));
		sept_s2  <= (year_s1 == cmr_pkg::CHANGE_YEAR) && (month_s1 == cmr_pkg::CHANGE_MONTH);
		ndays_s2 <= cmr_pkg::month_days(month_s1, leap_c);
		mt_s2    <= cmr_pkg::month_term(month_s1);
		k_s2     <= k_full_c[6:0];
		c_s2     <= cz_s1;
	end

	// Stage 3: congruence sum, kept positive by the bias.
	always_comb begin
		if (greg_s2) begin
			sum_c = cmr_pkg::ZELLER_BIAS + 10'd1 + 10'(mt_s2) + 10'(k_s2) + 10'(k_s2[6:2]) +
				10'(c_s2[6:2]) - 10'({c_s2, 1'b0});
		end else begin
			sum_c = cmr_pkg::ZELLER_BIAS + 10'd6 + 10'(mt_s2) + 10'(k_s2) + 10'(k_s2[6:2]) -
				10'(c_s2);
		end
	end

	always_ff @(posedge clk) begin
		ok_s3    <= ok_s2;
		sept_s3  <= sept_s2;
		row_s3   <= row_s2;
		ndays_s3 <= ndays_s2;
		sum_s3   <= sum_c;
	end

	// Stage 4: weekday of the first.
	always_ff @(posedge clk) begin
		ok_s4    <= ok_s3;
		sept_s4  <= sept_s3;
		row_s4   <= row_s3;
		ndays_s4 <= ndays_s3;
		dow_s4   <= cmr_pkg::mod7(sum_s3);
	end

	// Stage 5: seven independent column lanes.
	always_comb begin
		hi_c = 7'(ndays_s4) + 7'(dow_s4);
		for (int x = 0; x < 7; x++) begin
			idx_c[x] = 7'(row_s4) * 7'd7 + 7'(x);
			if (sept_s4 && (idx_c[x] + 7'd1 > 7'(dow_s4) + 7'd2)) begin
				idx_c[x] = idx_c[x] + cmr_pkg::SKIPPED_DAYS;
			end
			if (ok_s4 && (idx_c[x] >= 7'(dow_s4)) && (idx_c[x] < hi_c)) begin
				day_c[x] = 5'(idx_c[x] - 7'(dow_s4) + 7'd1);
			end else begin
				day_c[x] = 5'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int x = 0; x < 7; x++) begin
			day_s5[x] <= day_c[x];
		end
		ndays_s5 <= ok_s4 ? ndays_s4 : 5'd0;
		dow_s5   <= ok_s4 ? dow_s4 : 3'd0;
	end

	assign done          = vld_s5;
	assign day_col0      = day_s5[0];
	assign day_col1      = day_s5[1];
	assign day_col2      = day_s5[2];
	assign day_col3      = day_s5[3];
	assign day_col4      = day_s5[4];
	assign day_col5      = day_s5[5];
	assign day_col6      = day_s5[6];
	assign days_in_month = ndays_s5;
	assign first_weekday = dow_s5;

endmodule

// File: sv/cmr_checker.sv
// Port-level checker for the calendar month week row core, bound to the core module.
// Depends on cmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [4:0] days_in_month,
	input logic [2:0] first_weekday
);

	`ASSERT_DELAY(a_start_gives_done, clk, arst_n, start && !busy, cmr_pkg::LATENCY, done)
	`ASSERT_DELAY(a_no_spurious_done, clk, arst_n, !(start && !busy), cmr_pkg::LATENCY, !done)
	`ASSERT_SAME(a_weekday_range, clk, arst_n, done, first_weekday <= 3'd6)
	`ASSERT_SAME(a_length_range, clk, arst_n, done && (days_in_month != 5'd0), (days_in_month >= 5'd28) && (days_in_month <= 5'd31))

endmodule

bind calendar_month_week_row_core cmr_checker u_cmr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.days_in_month (days_in_month),
	.first_weekday (first_weekday)
);
